### sv/md4_pkg.sv
// ----------------------------------------------------------------------------
// md4_pkg
// Shared types, constants and round helpers for the MD4 hash engine.
// ----------------------------------------------------------------------------
package md4_pkg;

	localparam logic [31:0] IV_A = 32'h67452301;
	localparam logic [31:0] IV_B = 32'hefcdab89;
	localparam logic [31:0] IV_C = 32'h98badcfe;
	localparam logic [31:0] IV_D = 32'h10325476;

	localparam logic [31:0] K_R1 = 32'h00000000;
	localparam logic [31:0] K_R2 = 32'h5a827999;
	localparam logic [31:0] K_R3 = 32'h6ed9eba1;

	localparam logic [31:0] PAD_BYTE = 32'h00000080;
	localparam logic [3:0]  LEN_LO_POS = 4'd14;
	localparam logic [3:0]  LAST_POS = 4'd15;
	localparam logic [5:0]  LAST_STEP = 6'd47;
	localparam logic [2:0]  FULL_WORD = 3'd4;

	// block buffer write port
	typedef struct packed {
		logic        en;
		logic [3:0]  addr;
		logic [31:0] data;
	} md4_wr_t;

	// message word order per round group
	function automatic logic [3:0] msg_index(input logic [1:0] grp, input logic [3:0] i);
		logic [3:0] idx;
		idx = i;
		unique case (grp)
			2'd0: idx = i;
			2'd1: idx = {i[1:0], i[3:2]};
			2'd2: idx = {i[0], i[1], i[2], i[3]};
			default: idx = i;
		endcase
		return idx;
	endfunction

	function automatic logic [4:0] rot_amount(input logic [1:0] grp, input logic [1:0] ph);
		logic [4:0] s;
		s = 5'd3;
		unique case ({grp, ph})
			4'b00_00: s = 5'd3;
			4'b00_01: s = 5'd7;
			4'b00_10: s = 5'd11;
			4'b00_11: s = 5'd19;
			4'b01_00: s = 5'd3;
			4'b01_01: s = 5'd5;
			4'b01_10: s = 5'd9;
			4'b01_11: s = 5'd13;
			4'b10_00: s = 5'd3;
			4'b10_01: s = 5'd9;
			4'b10_10: s = 5'd11;
			4'b10_11: s = 5'd15;
			default: s = 5'd3;
		endcase
		return s;
	endfunction

	function automatic logic [31:0] round_const(input logic [1:0] grp);
		logic [31:0] k;
		k = K_R1;
		unique case (grp)
			2'd0: k = K_R1;
			2'd1: k = K_R2;
			2'd2: k = K_R3;
			default: k = K_R1;
		endcase
		return k;
	endfunction

endpackage

### sv/md4_block_buf.sv
// ----------------------------------------------------------------------------
// md4_block_buf
// Sixteen-word message block store, one write and one read port.
// ----------------------------------------------------------------------------
module md4_block_buf (
	input  logic             clk,
	input  md4_pkg::md4_wr_t wr,
	input  logic [3:0]       rd_addr,
	output logic [31:0]      rd_data
);

	logic [31:0] mem_q [16];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = mem_q[rd_addr];

endmodule

### sv/md4_step.sv
// ----------------------------------------------------------------------------
// md4_step
// One MD4 step: a' = rotl(a + F(b,c,d) + x + k, s). Shared by all 48 steps.
// ----------------------------------------------------------------------------
module md4_step (
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic [31:0] c,
	input  logic [31:0] d,
	input  logic [31:0] x,
	input  logic [1:0]  grp,
	input  logic [1:0]  ph,
	output logic [31:0] a_next
);

	logic [31:0] f;
	logic [31:0] sum;
	logic [4:0]  s;
	logic [63:0] dbl;

	always_comb begin
		unique case (grp)
			2'd0: f = d ^ (b & (c ^ d));
			2'd1: f = (b & c) | (b & d) | (c & d);
			2'd2: f = b ^ c ^ d;
			default: f = b ^ c ^ d;
		endcase
	end

	assign sum    = a + f + x + md4_pkg::round_const(grp);
	assign s      = md4_pkg::rot_amount(grp, ph);
	assign dbl    = {sum, sum} << s;
	assign a_next = dbl[63:32];

endmodule

### sv/md4_hash_engine.sv
// ----------------------------------------------------------------------------
// md4_hash_engine
// Streaming MD4 digest over little-endian 32-bit message words.
//
// Message words enter one per cycle while the 16-word block fills; the word
// that completes a block starts the compression, during which msg_stall is
// high. Compression runs the 48 MD4 steps through a single shared step unit,
// one step per cycle, then the S_FIN state adds the result into the chaining
// value. On the item marked last, the padding words (0x80, zero fill, 64-bit
// bit length) are written one per cycle between compressions, giving one or
// two extra compressions, and the four digest words A, B, C, D then leave on
// the digest channel, index 0 first, digest_end on the fourth. The engine
// returns to its initial state once the fourth digest word is taken and
// accepts no message word while digest words are pending.
// ----------------------------------------------------------------------------
module md4_hash_engine (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        msg_valid,
	output logic        msg_stall,
	input  logic [31:0] data_word,
	input  logic [2:0]  byte_count,
	input  logic        last,

	output logic        dig_valid,
	input  logic        dig_stall,
	output logic [31:0] digest_word,
	output logic [1:0]  word_index,
	output logic        digest_end
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PAD,
		S_COMP,
		S_FIN,
		S_OUT
	} state_t;

	state_t      state_q;
	logic [31:0] cv_q [4];     // chaining value A..D
	logic [31:0] v_q [4];      // working a, b, c, d (rotated each step)
	logic [3:0]  pos_q;        // next block slot
	logic [63:0] bytes_q;      // message length in bytes
	logic [5:0]  step_q;       // compression step 0..47
	logic        need80_q;     // full last word: pad byte goes in its own word
	logic        lenlo_q;      // low length word written
	logic        pad_q;        // padding in progress
	logic        final_q;      // high length word written
	logic        dig_valid_q;
	logic [1:0]  idx_q;

	logic             msg_acc;
	logic [2:0]       cnt_sat;
	logic [31:0]      last_word;
	md4_pkg::md4_wr_t wr;
	logic [31:0]      blk_rd;
	logic [31:0]      a_next;

	assign msg_acc = msg_valid && !msg_stall;
	assign msg_stall = (state_q != S_IDLE);
	assign cnt_sat = (byte_count > md4_pkg::FULL_WORD) ? md4_pkg::FULL_WORD : byte_count;

	// short last word: keep valid bytes, pad byte right after them
	always_comb begin
		unique case (cnt_sat)
			3'd0: last_word = md4_pkg::PAD_BYTE;
			3'd1: last_word = {16'h0000, 8'h80, data_word[7:0]};
			3'd2: last_word = {8'h00, 8'h80, data_word[15:0]};
			3'd3: last_word = {8'h80, data_word[23:0]};
			default: last_word = data_word;
		endcase
	end

	// block write source
	always_comb begin
		wr.en   = 1'b0;
		wr.addr = pos_q;
		wr.data = data_word;
		if (state_q == S_IDLE) begin
			wr.en   = msg_acc;
			wr.data = last ? last_word : data_word;
		end else if (state_q == S_PAD) begin
			wr.en = 1'b1;
			priority if (need80_q) begin
				wr.data = md4_pkg::PAD_BYTE;
			end else if (lenlo_q) begin
				wr.data = bytes_q[60:29];
			end else if (pos_q == md4_pkg::LEN_LO_POS) begin
				wr.data = {bytes_q[28:0], 3'b000};
			end else begin
				wr.data = '0;
			end
		end
	end

	md4_block_buf u_buf (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (md4_pkg::msg_index(step_q[5:4], step_q[3:0])),
		.rd_data (blk_rd)
	);

	md4_step u_step (
		.a      (v_q[0]),
		.b      (v_q[1]),
		.c      (v_q[2]),
		.d      (v_q[3]),
		.x      (blk_rd),
		.grp    (step_q[5:4]),
		.ph     (step_q[1:0]),
		.a_next (a_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cv_q[0]     <= md4_pkg::IV_A;
			cv_q[1]     <= md4_pkg::IV_B;
			cv_q[2]     <= md4_pkg::IV_C;
			cv_q[3]     <= md4_pkg::IV_D;
			pos_q       <= '0;
			bytes_q     <= '0;
			step_q      <= '0;
			need80_q    <= 1'b0;
			lenlo_q     <= 1'b0;
			pad_q       <= 1'b0;
			final_q     <= 1'b0;
			dig_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (msg_acc) begin
						bytes_q <= bytes_q + {61'd0, (last ? cnt_sat : md4_pkg::FULL_WORD)};
						pos_q   <= pos_q + 4'd1;
						if (last) begin
							need80_q <= (cnt_sat == md4_pkg::FULL_WORD);
							lenlo_q  <= 1'b0;
							pad_q    <= 1'b1;
							final_q  <= 1'b0;
						end
						if (pos_q == md4_pkg::LAST_POS) begin
							state_q <= S_COMP;
							step_q  <= '0;
							v_q     <= cv_q;
						end else if (last) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					pos_q <= pos_q + 4'd1;
					priority if (need80_q) begin
						need80_q <= 1'b0;
					end else if (lenlo_q) begin
						final_q <= 1'b1;
					end else if (pos_q == md4_pkg::LEN_LO_POS) begin
						lenlo_q <= 1'b1;
					end
					if (pos_q == md4_pkg::LAST_POS) begin
						state_q <= S_COMP;
						step_q  <= '0;
						v_q     <= cv_q;
					end
				end
				S_COMP: begin
					// next step targets d: shift roles down
					v_q[0] <= v_q[3];
					v_q[1] <= a_next;
					v_q[2] <= v_q[1];
					v_q[3] <= v_q[2];
					step_q <= step_q + 6'd1;
					if (step_q == md4_pkg::LAST_STEP) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					for (int i = 0; i < 4; i++) begin
						cv_q[i] <= cv_q[i] + v_q[i];
					end
					priority if (final_q) begin
						state_q     <= S_OUT;
						dig_valid_q <= 1'b1;
						idx_q       <= '0;
					end else if (pad_q) begin
						state_q <= S_PAD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_OUT: begin
					if (!dig_stall) begin
						if (idx_q == 2'd3) begin
							dig_valid_q <= 1'b0;
							state_q     <= S_IDLE;
							cv_q[0]     <= md4_pkg::IV_A;
							cv_q[1]     <= md4_pkg::IV_B;
							cv_q[2]     <= md4_pkg::IV_C;
							cv_q[3]     <= md4_pkg::IV_D;
							pos_q       <= '0;
							bytes_q     <= '0;
							pad_q       <= 1'b0;
							final_q     <= 1'b0;
							lenlo_q     <= 1'b0;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign dig_valid   = dig_valid_q;
	assign digest_word = cv_q[idx_q];
	assign word_index  = idx_q;
	assign digest_end  = (idx_q == 2'd3);

`ifndef SYNTHESIS
	// no message word taken while digest words are pending
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid |-> msg_stall)
		else $error("message accepted during digest output");

	// digest words advance in order after a taken non-final word
	a_idx_advance: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_stall && !digest_end |=>
		dig_valid && word_index == $past(word_index) + 2'd1)
		else $error("digest index did not advance");

	// a last word always starts padding work
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && !msg_stall && last |=> msg_stall)
		else $error("engine idle after last word");

	// compression never overlaps digest output
	a_comp_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMP) |-> !dig_valid)
		else $error("digest valid during compression");
`endif

endmodule

### bench/tb_md4_hash_engine.sv
// ----------------------------------------------------------------------------
// tb_md4_hash_engine
// Self-checking bench for the streaming MD4 engine. A queue of message words
// (directed corner cases, then random messages) feeds a clocked driver; a
// clocked monitor checks each digest word against an in-bench MD4 model.
// ----------------------------------------------------------------------------
module tb_md4_hash_engine;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_GOAL    = 460;
	localparam int TAIL_ITEMS   = 50;   // last stretch runs with no idling
	localparam int HOLD_AFTER   = 20;   // digest words seen before the long hold
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 250;  // quiet tail after the last digest word
	// longest quiet stretch: long hold plus a few compressions
	localparam int QUIET_LIMIT  = 5000;

	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  cnt;
		logic        fin;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [1:0]  idx;
		logic        fin;
	} digest_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        msg_valid = 1'b0;
	logic        msg_stall;
	logic [31:0] data_word = '0;
	logic [2:0]  byte_count = '0;
	logic        last = 1'b0;
	logic        dig_valid;
	logic        dig_stall = 1'b0;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        digest_end;

	msg_item_t msg_q[$];
	digest_t   digest_due[$];
	int        errors = 0;

	// model state
	logic [31:0] chain_st [4];
	logic [31:0] blk_st [16];
	int          pos_st;
	logic [63:0] len_bytes;

	md4_hash_engine uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.msg_valid   (msg_valid),
		.msg_stall   (msg_stall),
		.data_word   (data_word),
		.byte_count  (byte_count),
		.last        (last),
		.dig_valid   (dig_valid),
		.dig_stall   (dig_stall),
		.digest_word (digest_word),
		.word_index  (word_index),
		.digest_end  (digest_end)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// MD4 model
	// ------------------------------------------------------------------------
	function automatic void chain_init();
		chain_st[0] = md4_pkg::IV_A;
		chain_st[1] = md4_pkg::IV_B;
		chain_st[2] = md4_pkg::IV_C;
		chain_st[3] = md4_pkg::IV_D;
		pos_st = 0;
		len_bytes = '0;
	endfunction

	// word order: round 2 walks columns, round 3 walks bit-reversed indexes
	function automatic int pick_word(input int grp, input int i);
		int sel;
		sel = i;
		if (grp == 1)
			sel = (i % 4) * 4 + i / 4;
		else if (grp == 2)
			sel = ((i & 1) << 3) | ((i & 2) << 1) | ((i & 4) >> 1) | ((i & 8) >> 3);
		return sel;
	endfunction

	function automatic int shift_of(input int grp, input int ph);
		int s;
		s = 3;
		case (grp)
			0: s = (ph == 0) ? 3 : (ph == 1) ? 7 : (ph == 2) ? 11 : 19;
			1: s = (ph == 0) ? 3 : (ph == 1) ? 5 : (ph == 2) ? 9 : 13;
			default: s = (ph == 0) ? 3 : (ph == 1) ? 9 : (ph == 2) ? 11 : 15;
		endcase
		return s;
	endfunction

	function automatic void md4_compress();
		logic [31:0] v [4];
		logic [31:0] f, t, kc;
		int a, b, c, d, ph, sh;
		for (int k = 0; k < 4; k++)
			v[k] = chain_st[k];
		for (int g = 0; g < 3; g++) begin
			kc = (g == 0) ? md4_pkg::K_R1 : (g == 1) ? md4_pkg::K_R2 : md4_pkg::K_R3;
			for (int i = 0; i < 16; i++) begin
				ph = i & 3;
				a = (4 - ph) & 3;
				b = (5 - ph) & 3;
				c = (6 - ph) & 3;
				d = (7 - ph) & 3;
				if (g == 0)
					f = v[d] ^ (v[b] & (v[c] ^ v[d]));
				else if (g == 1)
					f = (v[b] & v[c]) | (v[b] & v[d]) | (v[c] & v[d]);
				else
					f = v[b] ^ v[c] ^ v[d];
				t = v[a] + f + blk_st[pick_word(g, i)] + kc;
				sh = shift_of(g, ph);
				v[a] = (t << sh) | (t >> (32 - sh));
			end
		end
		for (int k = 0; k < 4; k++)
			chain_st[k] = chain_st[k] + v[k];
	endfunction

	function automatic void blk_push(input logic [31:0] w);
		blk_st[pos_st] = w;
		pos_st = (pos_st + 1) % 16;
		if (pos_st == 0)
			md4_compress();
	endfunction

	// absorb one accepted item; a last item queues the four digest words
	function automatic void md4_absorb(input logic [31:0] dw, input logic [2:0] bc,
			input logic fin);
		int n;
		logic [31:0] mask;
		logic [63:0] nbits;
		digest_t r;
		n = (bc > md4_pkg::FULL_WORD) ? 4 : int'(bc);
		if (!fin) begin
			// count ignored on inner words
			len_bytes = len_bytes + 64'd4;
			blk_push(dw);
			return;
		end
		len_bytes = len_bytes + 64'(n);
		if (n == 4) begin
			blk_push(dw);
			blk_push(md4_pkg::PAD_BYTE);
		end else begin
			mask = (n == 0) ? 32'h0 : (32'hffffffff >> (32 - 8 * n));
			blk_push((dw & mask) | (md4_pkg::PAD_BYTE << (8 * n)));
		end
		while (pos_st != int'(md4_pkg::LEN_LO_POS))
			blk_push(32'h0);
		nbits = len_bytes << 3;
		blk_push(nbits[31:0]);
		blk_push(nbits[63:32]);
		for (int k = 0; k < 4; k++) begin
			r.word = chain_st[k];
			r.idx = 2'(k);
			r.fin = (k == 3);
			digest_due.push_back(r);
		end
		chain_init();
	endfunction

	// ------------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------------
	function automatic void add_word(input logic [31:0] dw, input logic [2:0] bc,
			input logic fin);
		msg_item_t it;
		it.data = dw;
		it.cnt = bc;
		it.fin = fin;
		msg_q.push_back(it);
	endfunction

	// nfull inner words of random content, then the last word
	function automatic void add_message(input int nfull, input logic [2:0] tail_cnt);
		logic [2:0] bc;
		for (int i = 0; i < nfull; i++) begin
			// now and then an inner word carries a stray byte count
			bc = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(0, 7))
				: md4_pkg::FULL_WORD;
			add_word($urandom, bc, 1'b0);
		end
		add_word($urandom, tail_cnt, 1'b1);
	endfunction

	function automatic bit in_tail();
		return msg_q.size() < TAIL_ITEMS;
	endfunction

	// ------------------------------------------------------------------------
	// driver: random idle bursts, payload held while stalled
	// ------------------------------------------------------------------------
	int send_gap;

	always @(posedge clk or negedge arst_n) begin : drv_proc
		msg_item_t nxt;
		if (!arst_n) begin
			msg_valid <= 1'b0;
			data_word <= '0;
			byte_count <= '0;
			last <= 1'b0;
			send_gap <= 0;
		end else begin
			if (msg_valid && !msg_stall)
				md4_absorb(data_word, byte_count, last);
			if (!(msg_valid && msg_stall)) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					msg_valid <= 1'b0;
				end else if (msg_q.size() == 0) begin
					msg_valid <= 1'b0;
				end else if (!in_tail() && $urandom_range(0, 9) == 0) begin
					send_gap <= $urandom_range(0, 14);
					msg_valid <= 1'b0;
				end else begin
					nxt = msg_q.pop_front();
					data_word <= nxt.data;
					byte_count <= nxt.cnt;
					last <= nxt.fin;
					msg_valid <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: checks digest words, stalls in bursts, one long hold so the
	// engine backs up into its message input
	// ------------------------------------------------------------------------
	int  stall_left;
	int  words_seen;
	bit  held_long;

	always @(posedge clk or negedge arst_n) begin : mon_proc
		digest_t want;
		if (!arst_n) begin
			dig_stall <= 1'b0;
			stall_left <= 0;
			words_seen <= 0;
			held_long <= 1'b0;
		end else begin
			if (dig_valid && !dig_stall) begin
				words_seen <= words_seen + 1;
				if (digest_due.size() == 0) begin
					$error("unexpected digest word %h", digest_word);
					errors++;
				end else begin
					want = digest_due.pop_front();
					if (digest_word !== want.word) begin
						$error("digest_word: expected %h, got %h", want.word, digest_word);
						errors++;
					end
					if (word_index !== want.idx) begin
						$error("word_index: expected %0d, got %0d", want.idx, word_index);
						errors++;
					end
					if (digest_end !== want.fin) begin
						$error("digest_end: expected %0b, got %0b", want.fin, digest_end);
						errors++;
					end
				end
			end
			if (!held_long && words_seen >= HOLD_AFTER) begin
				held_long <= 1'b1;
				stall_left <= HOLD_CYCLES;
				dig_stall <= 1'b1;
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				dig_stall <= 1'b1;
			end else if (!in_tail() && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(0, 14);
				dig_stall <= 1'b1;
			end else begin
				dig_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: too long with no item moving on either side
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((msg_valid && !msg_stall) || (dig_valid && !dig_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int pick;
		int nfull;
		chain_init();

		// directed: empty message, every last-word count, masking of dead bytes
		add_word(32'h0, 3'd0, 1'b1);
		add_word(32'hffffffff, 3'd1, 1'b1);
		add_word(32'hffffffff, 3'd2, 1'b1);
		add_word(32'hffffffff, 3'd3, 1'b1);
		add_word(32'hffffffff, 3'd4, 1'b1);
		// counts above four saturate
		add_word(32'hffffffff, 3'd5, 1'b1);
		add_word(32'ha5a55a5a, 3'd6, 1'b1);
		add_word(32'hffffffff, 3'd7, 1'b1);
		add_word(32'h0, 3'd4, 1'b1);
		// short inner word is taken whole
		add_word(32'hffffffff, 3'd2, 1'b0);
		add_word(32'h0, 3'd0, 1'b1);
		// full word at slot 13 pushes padding into a second final block
		add_message(13, 3'd4);

		// random messages: mostly short, some spanning blocks, some near the
		// padding boundary
		while (msg_q.size() < ITEM_GOAL) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				nfull = $urandom_range(0, 15);
			else if (pick < 9)
				nfull = $urandom_range(16, 40);
			else
				nfull = $urandom_range(12, 15);
			add_message(nfull, 3'($urandom_range(0, 7)));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// sample off the active edge so the driver's pops have settled
		while (msg_q.size() != 0 || msg_valid || digest_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
sv/md4_pkg.sv
sv/md4_block_buf.sv
sv/md4_step.sv
sv/md4_hash_engine.sv
bench/tb_md4_hash_engine.sv
